FILE: rtl/lru_page_replacement_assert.svh
// Assertion macros for the LRU page replacement block.
// Used by the port checker; expects clk and rst in the calling scope.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// same-cycle implication
`define LRUPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrupr port check failed");

// next-cycle implication
`define LRUPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrupr port check failed");

`endif

FILE: rtl/lrupr_pkg.sv
// Shared constants and controller/datapath interface types for the
// LRU page replacement block. No dependencies.
package lrupr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int CFG_W          = 4;
  localparam int FRAME_OUT_W    = 3;
  localparam int COUNT_W        = 32;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // request accepted: latch page, clear on restart
    logic scan;    // read one frame of the page store
    logic update;  // apply hit/fill/replace and post the result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_last;  // current scan index is the last active frame
  } sts_t;

endpackage

FILE: rtl/lrupr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on lrupr_pkg for default sizes.
module lrupr_ram #(
  parameter int WIDTH = lrupr_pkg::PAGE_BITS_DEF,
  parameter int DEPTH = lrupr_pkg::MAX_FRAMES_DEF
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lrupr_ctrl.sv
// Sequencer for the LRU page replacement block: accept, scan, drain, update.
// Depends on lrupr_pkg for the command and status structs.
module lrupr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lrupr_pkg::sts_t   sts,
  output logic              busy,
  output lrupr_pkg::cmd_t   cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      // last read data lands in the compare stage
      S_DRAIN: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: rtl/lrupr_dp.sv
// Datapath: frame state (page RAM, valid bits, recency ranks), scan compare,
// victim selection, rank update and fault counter. Depends on lrupr_pkg, lrupr_ram.
module lrupr_dp #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lrupr_pkg::CFG_W-1:0]         frames_in_use,
  input  logic [PAGE_BITS-1:0]                page_number,
  input  logic                                restart,
  input  lrupr_pkg::cmd_t                     cmd,
  output lrupr_pkg::sts_t                     sts,
  output logic                                done,
  output logic                                fault,
  output logic [lrupr_pkg::FRAME_OUT_W-1:0]   frame_used,
  output logic [lrupr_pkg::COUNT_W-1:0]       fault_count
);

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_W = IDX_W;

  // configuration
  logic [lrupr_pkg::CFG_W-1:0] cfg_frames;
  logic [IDX_W-1:0]            last_calc;
  logic [IDX_W-1:0]            last_idx;

  // request and scan
  logic [PAGE_BITS-1:0] page_q;
  logic [IDX_W-1:0]     scan_idx;
  logic                 cmp_en;
  logic [IDX_W-1:0]     cmp_idx;
  logic [PAGE_BITS-1:0] rd_page;
  logic                 cmp_valid;
  logic [RANK_W-1:0]    cmp_rank;
  logic                 cmp_hit;

  // scan results
  logic              hit_found;
  logic              free_found;
  logic [IDX_W-1:0]  hit_idx;
  logic [RANK_W-1:0] hit_rank;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  best_idx;
  logic [RANK_W-1:0] best_rank;

  // frame state
  logic [MAX_FRAMES-1:0] valid;
  logic [MAX_FRAMES-1:0] valid_next;
  logic [RANK_W-1:0]     rank      [MAX_FRAMES];
  logic [RANK_W-1:0]     rank_next [MAX_FRAMES];
  logic [lrupr_pkg::COUNT_W-1:0] fault_total;

  // update decision
  logic [IDX_W-1:0]  used_idx;
  logic [RANK_W-1:0] old_rank;
  logic              touch_all;

  // frame count register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_frames <= lrupr_pkg::FRAMES_RESET;
    end else if (cfg_write) begin
      cfg_frames <= frames_in_use;
    end
  end

  // clamp frame count into 1..MAX_FRAMES, kept as last index
  always_comb begin
    if (cfg_frames == '0) begin
      last_calc = '0;
    end else if (int'(cfg_frames) > MAX_FRAMES) begin
      last_calc = IDX_W'(MAX_FRAMES - 1);
    end else begin
      last_calc = IDX_W'(cfg_frames - 1'b1);
    end
  end

  // request latch and scan counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_q   <= page_number;
      last_idx <= last_calc;
      scan_idx <= '0;
    end else if (cmd.scan && !sts.scan_last) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  assign sts.scan_last = (scan_idx == last_idx);

  // page store, one read per scan cycle
  lrupr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (cmd.update && !hit_found),
    .waddr (used_idx),
    .wdata (page_q),
    .raddr (scan_idx),
    .rdata (rd_page)
  );

  // compare stage, aligned with registered read data
  assign cmp_valid = valid[cmp_idx];
  assign cmp_rank  = rank[cmp_idx];
  assign cmp_hit   = cmp_valid && (rd_page == page_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en     <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      if (cmd.load) begin
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else if (cmp_en) begin
        if (cmp_hit) begin
          hit_found <= 1'b1;
        end
        if (!cmp_valid) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  // first hit, first free frame, highest rank (lowest index on tie)
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (cmp_en) begin
      if (cmp_hit && !hit_found) begin
        hit_idx  <= cmp_idx;
        hit_rank <= cmp_rank;
      end
      if (!cmp_valid && !free_found) begin
        free_idx <= cmp_idx;
      end
      if (cmp_idx == '0 || cmp_rank > best_rank) begin
        best_idx  <= cmp_idx;
        best_rank <= cmp_rank;
      end
    end
  end

  // pick the frame and the aging threshold
  assign touch_all = !hit_found && free_found;
  assign used_idx  = hit_found ? hit_idx : (free_found ? free_idx : best_idx);
  assign old_rank  = hit_found ? hit_rank : best_rank;

  // per-frame valid and rank update
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      valid_next[i] = valid[i];
      rank_next[i]  = rank[i];
      if (cmd.load && restart) begin
        valid_next[i] = 1'b0;
        rank_next[i]  = '0;
      end else if (cmd.update) begin
        if (IDX_W'(i) == used_idx) begin
          valid_next[i] = 1'b1;
          rank_next[i]  = '0;
        end else if (valid[i] && (touch_all || rank[i] < old_rank)) begin
          rank_next[i] = rank[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      valid <= valid_next;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  // saturating fault counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_total <= '0;
    end else if (cmd.load && restart) begin
      fault_total <= '0;
    end else if (cmd.update && !hit_found && fault_total != '1) begin
      fault_total <= fault_total + 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      fault      <= !hit_found;
      frame_used <= lrupr_pkg::FRAME_OUT_W'(used_idx);
    end
  end

  assign fault_count = fault_total;

endmodule

FILE: rtl/lru_page_replacement.sv
// Top level of the LRU page replacement block with fault counting.
// Depends on lrupr_pkg, lrupr_ctrl, lrupr_dp (and lrupr_ram below it).
//
//   channel   handshake           payload
//   config    cfg_write           frames_in_use
//   request   start / busy        page_number, restart
//   result    done (1-cycle)      fault, frame_used, fault_count
//
// A request runs from accept to the done strobe through a scan of the
// active frames (1..MAX_FRAMES): the page RAM is scanned one frame per
// cycle through its single read port, then come a drain and an update state.
// A new request may be accepted in the cycle that shows done.
// rst is synchronous, active high; it clears frames, count and sets
// frames_in_use to 8. Results cannot be stalled.
module lru_page_replacement #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lrupr_pkg::CFG_W-1:0]       frames_in_use,
  input  logic                              start,
  input  logic [PAGE_BITS-1:0]              page_number,
  input  logic                              restart,
  output logic                              busy,
  output logic                              done,
  output logic                              fault,
  output logic [lrupr_pkg::FRAME_OUT_W-1:0] frame_used,
  output logic [lrupr_pkg::COUNT_W-1:0]     fault_count
);

  lrupr_pkg::cmd_t cmd;
  lrupr_pkg::sts_t sts;

  // sequencer
  lrupr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // frame state and scan datapath
  lrupr_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .frames_in_use (frames_in_use),
    .page_number   (page_number),
    .restart       (restart),
    .cmd           (cmd),
    .sts           (sts),
    .done          (done),
    .fault         (fault),
    .frame_used    (frame_used),
    .fault_count   (fault_count)
  );

endmodule

FILE: rtl/lrupr_checker.sv
// Port-level checks for lru_page_replacement, bound onto the top level.
// Depends on lrupr_pkg and lru_page_replacement_assert.svh.
`include "lru_page_replacement_assert.svh"

module lrupr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic                          fault,
  input logic [lrupr_pkg::COUNT_W-1:0] fault_count
);

  // result only shows once the request is finished
  `LRUPR_ASSERT_IMP(a_done_idle, done, !busy)
  // an accepted request makes the block busy
  `LRUPR_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // a hit leaves the fault count alone
  `LRUPR_ASSERT_IMP(a_hit_count, done && !fault, fault_count == $past(fault_count))
  // a fault always leaves a nonzero count
  `LRUPR_ASSERT_IMP(a_fault_nonzero, done && fault, fault_count != '0)

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .fault       (fault),
  .fault_count (fault_count)
);

FILE: tb/sv/lru_page_replacement_test.sv
// Self-checking testbench for lru_page_replacement: directed table, then random reference strings.
// Predicts hit/fault, frame and fault count per request; depends on lrupr_pkg and the RTL only.
module lru_page_replacement_test;

  localparam int MAXF      = lrupr_pkg::MAX_FRAMES_DEF;
  localparam int PAGE_W    = lrupr_pkg::PAGE_BITS_DEF;
  localparam int CYCLE_CAP = 300000;
  localparam int NUM_DIR   = 25;
  localparam int PER_PHASE = 145;
  localparam int POOL_MAX  = 12;

  typedef struct packed {
    logic                              fault;
    logic [lrupr_pkg::FRAME_OUT_W-1:0] frame;
    logic [lrupr_pkg::COUNT_W-1:0]     count;
  } lru_result_t;

  // one directed row: optional register write, the request, optional typed-in answer
  typedef struct packed {
    logic                        wr_cfg;
    logic [lrupr_pkg::CFG_W-1:0] cfg;
    logic [PAGE_W-1:0]           page;
    logic                        clr;
    logic                        typed;
    lru_result_t                 want;
  } ref_row_t;

  localparam ref_row_t DIR_ROWS [NUM_DIR] = '{
    // after reset: empty frames fill in order
    '{1'b0, 4'd0,  16'h0000, 1'b0, 1'b1, '{1'b1, 3'd0, 32'd1}},
    '{1'b0, 4'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b1, 3'd1, 32'd2}},
    '{1'b0, 4'd0,  16'h0000, 1'b0, 1'b1, '{1'b0, 3'd0, 32'd2}},
    '{1'b0, 4'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 3'd1, 32'd2}},
    // restart clears frames and count first
    '{1'b0, 4'd0,  16'hFFFF, 1'b1, 1'b1, '{1'b1, 3'd0, 32'd1}},
    // frame count zero acts as one frame
    '{1'b1, 4'd0,  16'h0005, 1'b1, 1'b1, '{1'b1, 3'd0, 32'd1}},
    '{1'b0, 4'd0,  16'h0006, 1'b0, 1'b1, '{1'b1, 3'd0, 32'd2}},
    '{1'b0, 4'd0,  16'h0006, 1'b0, 1'b1, '{1'b0, 3'd0, 32'd2}},
    // frame count above the maximum acts as the maximum
    '{1'b1, 4'd15, 16'h1234, 1'b1, 1'b1, '{1'b1, 3'd0, 32'd1}},
    '{1'b0, 4'd0,  16'h0101, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0102, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0103, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0104, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0105, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0106, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0107, 1'b0, 1'b0, '0},
    // all full: replace least recent, then a hit
    '{1'b0, 4'd0,  16'h0200, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0102, 1'b0, 1'b0, '0},
    // count reduced while in use: upper frames neither hit nor get replaced
    '{1'b1, 4'd3,  16'h0105, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0106, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0105, 1'b0, 1'b0, '0},
    '{1'b1, 4'd8,  16'h0106, 1'b0, 1'b0, '0},
    '{1'b1, 4'd1,  16'hAAAA, 1'b0, 1'b0, '0},
    '{1'b1, 4'd2,  16'h5555, 1'b0, 1'b0, '0},
    '{1'b1, 4'd8,  16'h0000, 1'b1, 1'b1, '{1'b1, 3'd0, 32'd1}}
  };

  localparam logic [lrupr_pkg::CFG_W-1:0] CFG_PLAN [9] = '{
    4'd8, 4'd2, 4'd15, 4'd1, 4'd5, 4'd0, 4'd3, 4'd12, 4'd7
  };
  localparam int IDLE_PCT [3] = '{29, 49, 0};

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [lrupr_pkg::CFG_W-1:0]       frames_in_use = lrupr_pkg::FRAMES_RESET;
  logic                              start = 1'b0;
  logic [PAGE_W-1:0]                 page_number = '0;
  logic                              restart = 1'b0;
  logic                              busy;
  logic                              done;
  logic                              fault;
  logic [lrupr_pkg::FRAME_OUT_W-1:0] frame_used;
  logic [lrupr_pkg::COUNT_W-1:0]     fault_count;

  // predictor state
  logic [PAGE_W-1:0]             page_tab  [MAXF];
  bit                            valid_tab [MAXF];
  int unsigned                   rank_tab  [MAXF];
  logic [lrupr_pkg::COUNT_W-1:0] faults_so_far;
  logic [lrupr_pkg::CFG_W-1:0]   frames_reg;

  lru_result_t pending_results [$];
  int          mismatches = 0;
  int          cycles = 0;

  lru_page_replacement dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .frames_in_use(frames_in_use),
    .start(start), .page_number(page_number), .restart(restart), .busy(busy),
    .done(done), .fault(fault), .frame_used(frame_used), .fault_count(fault_count)
  );

  always #5 clk = ~clk;

  // run-length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // frame k becomes most recent; more recent valid frames age by one
  function automatic void make_recent(input int k, input int unsigned old_rank);
    for (int i = 0; i < MAXF; i++) begin
      if (i != k && valid_tab[i] && rank_tab[i] < old_rank) rank_tab[i]++;
    end
    rank_tab[k] = 0;
  endfunction

  // LRU lookup with fill of free frames and saturating fault count
  task automatic lru_predict(input logic [PAGE_W-1:0] page, input logic clr,
                             output lru_result_t res);
    int n;
    int hit_idx;
    int free_idx;
    int victim;
    if (clr) begin
      for (int i = 0; i < MAXF; i++) begin
        valid_tab[i] = 1'b0;
        rank_tab[i]  = 0;
      end
      faults_so_far = '0;
    end
    n = frames_reg;
    if (n < 1) n = 1;
    if (n > MAXF) n = MAXF;
    hit_idx = -1;
    for (int i = 0; i < n; i++) begin
      if (hit_idx < 0 && valid_tab[i] && page_tab[i] == page) hit_idx = i;
    end
    if (hit_idx >= 0) begin
      make_recent(hit_idx, rank_tab[hit_idx]);
      res.fault = 1'b0;
      res.frame = hit_idx[lrupr_pkg::FRAME_OUT_W-1:0];
    end else begin
      free_idx = -1;
      for (int i = 0; i < n; i++) begin
        if (free_idx < 0 && !valid_tab[i]) free_idx = i;
      end
      if (free_idx >= 0) begin
        victim = free_idx;
        valid_tab[victim] = 1'b1;
        page_tab[victim]  = page;
        make_recent(victim, MAXF + 1);
      end else begin
        victim = 0;
        for (int i = 1; i < n; i++) begin
          if (rank_tab[i] > rank_tab[victim]) victim = i;
        end
        page_tab[victim] = page;
        make_recent(victim, rank_tab[victim]);
      end
      if (faults_so_far != '1) faults_so_far++;
      res.fault = 1'b1;
      res.frame = victim[lrupr_pkg::FRAME_OUT_W-1:0];
    end
    res.count = faults_so_far;
  endtask

  // drive one request and hold it until accepted
  task automatic issue_request(input logic [PAGE_W-1:0] page, input logic clr,
                               input bit typed, input lru_result_t want);
    lru_result_t res;
    start       <= 1'b1;
    page_number <= page;
    restart     <= clr;
    @(posedge clk);
    while (busy) @(posedge clk);
    lru_predict(page, clr, res);
    pending_results.insert(pending_results.size(), typed ? want : res);
  endtask

  // random sender idle cycles
  task automatic sender_pause(input int pct);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(0, 99) < pct) begin
      if (!lowered) begin
        start   <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk);
    end
  endtask

  // stop sending until every result is back
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_frames(input logic [lrupr_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_write     <= 1'b1;
    frames_in_use <= value;
    @(posedge clk);
    cfg_write  <= 1'b0;
    frames_reg = value;
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    lru_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result fault=%0b frame_used=%0d fault_count=%0d",
                 $time, fault, frame_used, fault_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (fault !== want.fault) begin
          $display("%0t: fault expected %0b actual %0b", $time, want.fault, fault);
          mismatches++;
        end
        if (frame_used !== want.frame) begin
          $display("%0t: frame_used expected %0d actual %0d", $time, want.frame, frame_used);
          mismatches++;
        end
        if (fault_count !== want.count) begin
          $display("%0t: fault_count expected %0d actual %0d",
                   $time, want.count, fault_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [PAGE_W-1:0]           hot_pages [POOL_MAX];
    int                          pool_size;
    int                          pick;
    logic [PAGE_W-1:0]           page;
    logic                        clr;
    logic [lrupr_pkg::CFG_W-1:0] cfg_val;

    frames_reg    = lrupr_pkg::FRAMES_RESET;
    faults_so_far = '0;
    for (int i = 0; i < MAXF; i++) begin
      valid_tab[i] = 1'b0;
      rank_tab[i]  = 0;
      page_tab[i]  = '0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < NUM_DIR; r++) begin
      if (DIR_ROWS[r].wr_cfg) write_frames(DIR_ROWS[r].cfg);
      issue_request(DIR_ROWS[r].page, DIR_ROWS[r].clr, DIR_ROWS[r].typed, DIR_ROWS[r].want);
      sender_pause(20);
    end

    // random reference strings with locality, plus noise and restarts
    for (int ph = 0; ph < 3; ph++) begin
      for (int sub = 0; sub < 3; sub++) begin
        cfg_val = (ph == 2 && sub == 2) ? 4'($urandom_range(0, 15)) : CFG_PLAN[ph*3 + sub];
        write_frames(cfg_val);
        pool_size = $urandom_range(2, POOL_MAX);
        for (int i = 0; i < POOL_MAX; i++) hot_pages[i] = PAGE_W'($urandom);
        for (int k = 0; k < PER_PHASE; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 75) begin
            page = hot_pages[$urandom_range(0, pool_size - 1)];
          end else if (pick < 85) begin
            page = ($urandom_range(0, 1) != 0) ? '1 : '0;
          end else begin
            page = PAGE_W'($urandom);
          end
          if ($urandom_range(0, 99) < 5) hot_pages[$urandom_range(0, pool_size - 1)] =
            PAGE_W'($urandom);
          clr = ($urandom_range(0, 99) < 2);
          issue_request(page, clr, 1'b0, '0);
          sender_pause(IDLE_PCT[ph]);
        end
      end
    end

    // drain and let the block settle
    wait_idle();
    repeat (MAXF + 6) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
